// ===== hw/rtl/lmbr_pkg.sv =====
// shared constants and types for the led matrix bitplane refresh block
// no dependencies; imported by the interfaces and all rtl modules
`timescale 1ns / 1ps

package lmbr_pkg;

    // fixed field widths of the input and result words
    localparam int OP_W       = 1;
    localparam int PIX_X_W    = 6;
    localparam int PIX_Y_W    = 5;
    localparam int LEVEL_W    = 4;
    localparam int ROW_SEL_W  = 4;
    localparam int RGB_W      = 3;

    // configuration port
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DELAY_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_UNIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE = 1'd1;
    localparam logic [DELAY_W-1:0]   DELAY_RESET    = 16'd200;

    // operation codes
    localparam logic [OP_W-1:0] OP_PIXEL_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK        = 1'b1;

    // default geometry
    localparam int DEF_PANEL_WIDTH  = 64;
    localparam int DEF_PANEL_HEIGHT = 32;
    localparam int DEF_COLOR_BITS   = 4;
    localparam int DEF_SCAN_HALVES  = 2;

    // control part of one tick result, produced by the sequencer
    typedef struct packed {
        logic [ROW_SEL_W-1:0] row_select;
        logic                 shift_strobe;
        logic                 latch_strobe;
        logic                 blank_n;
        logic                 frame_done;
    } t_tick_ctrl;

endpackage

// ===== hw/rtl/lmbr_in_if.sv =====
// input channel: pixel writes and refresh ticks
// depends on lmbr_pkg
`timescale 1ns / 1ps

interface lmbr_in_if import lmbr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    modport source (
        output valid, operation, pixel_x, pixel_y, red_level, green_level, blue_level,
        input  ready
    );
    modport sink (
        input  valid, operation, pixel_x, pixel_y, red_level, green_level, blue_level,
        output ready
    );
endinterface

// ===== hw/rtl/lmbr_out_if.sv =====
// output channel: one word of panel pin levels per refresh tick
// depends on lmbr_pkg
`timescale 1ns / 1ps

interface lmbr_out_if import lmbr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ROW_SEL_W-1:0] row_select;
    logic [RGB_W-1:0]     upper_rgb;
    logic [RGB_W-1:0]     lower_rgb;
    logic                 shift_strobe;
    logic                 latch_strobe;
    logic                 blank_n;
    logic                 frame_done;

    modport source (
        output valid, row_select, upper_rgb, lower_rgb, shift_strobe, latch_strobe,
               blank_n, frame_done,
        input  ready
    );
    modport sink (
        input  valid, row_select, upper_rgb, lower_rgb, shift_strobe, latch_strobe,
               blank_n, frame_done,
        output ready
    );
endinterface

// ===== hw/rtl/lmbr_frame_store.sv =====
// frame store: one synchronous ram per scan half, read data registered
// clears itself after reset; depends on lmbr_pkg
`timescale 1ns / 1ps

module lmbr_frame_store import lmbr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int COLOR_BITS   = DEF_COLOR_BITS,
    parameter int SCAN_HALVES  = DEF_SCAN_HALVES,
    localparam int ROW_PAIRS   = PANEL_HEIGHT / SCAN_HALVES,
    localparam int RW          = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1,
    localparam int CW          = $clog2(PANEL_WIDTH),
    localparam int DATA_W      = 3 * COLOR_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic              i_wr_lower,
    input  logic [RW-1:0]     i_wr_row,
    input  logic [CW-1:0]     i_wr_col,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [RW-1:0]     i_rd_row,
    input  logic [CW-1:0]     i_rd_col,
    output logic [DATA_W-1:0] o_rd_upper,
    output logic [DATA_W-1:0] o_rd_lower,
    output logic              o_busy
);

    localparam int AW    = RW + CW;
    localparam int DEPTH = ROW_PAIRS * (2 ** CW);

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic              we_upper;
    logic              we_lower;

    // clearing sweep after reset, both halves in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        rd_addr = {i_rd_row, i_rd_col};
        if (r_clearing) begin
            wr_addr  = r_clr_addr;
            wr_data  = '0;
            we_upper = 1'b1;
            we_lower = 1'b1;
        end else begin
            wr_addr  = {i_wr_row, i_wr_col};
            wr_data  = i_wr_data;
            we_upper = i_we && !i_wr_lower;
            we_lower = i_we && i_wr_lower;
        end
    end

    logic [DATA_W-1:0] mem_upper [DEPTH];
    logic [DATA_W-1:0] r_rd_upper;

    always_ff @(posedge i_clk) begin
        if (we_upper) begin
            mem_upper[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_upper <= mem_upper[rd_addr];
        end
    end

    assign o_rd_upper = r_rd_upper;
    assign o_busy     = r_clearing;

    generate
        if (SCAN_HALVES > 1) begin : g_lower
            logic [DATA_W-1:0] mem_lower [DEPTH];
            logic [DATA_W-1:0] r_rd_lower;

            always_ff @(posedge i_clk) begin
                if (we_lower) begin
                    mem_lower[wr_addr] <= wr_data;
                end
                if (i_rd_en) begin
                    r_rd_lower <= mem_lower[rd_addr];
                end
            end

            assign o_rd_lower = r_rd_lower;
        end else begin : g_no_lower
            // single scan half: lower lines stay dark
            assign o_rd_lower = we_lower ? '0 : '0;
        end
    endgenerate

endmodule

// ===== hw/rtl/lmbr_sequencer.sv =====
// scan sequencer: row, plane, column and dwell counters of the refresh
// issues the frame store read for shift ticks; depends on lmbr_pkg
`timescale 1ns / 1ps

module lmbr_sequencer import lmbr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int COLOR_BITS   = DEF_COLOR_BITS,
    parameter int SCAN_HALVES  = DEF_SCAN_HALVES,
    localparam int ROW_PAIRS   = PANEL_HEIGHT / SCAN_HALVES,
    localparam int RW          = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1,
    localparam int CW          = $clog2(PANEL_WIDTH),
    localparam int PW          = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_run,
    input  logic [DELAY_W-1:0] i_delay_unit,
    output logic               o_rd_en,
    output logic [RW-1:0]      o_rd_row,
    output logic [CW-1:0]      o_rd_col,
    output t_tick_ctrl         o_ctrl,
    output logic [PW-1:0]      o_plane
);

    localparam int DW = DELAY_W + COLOR_BITS - 1;

    typedef enum logic [1:0] {
        PH_SHIFT = 2'd0,
        PH_LATCH = 2'd1,
        PH_DWELL = 2'd2
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [RW-1:0] r_row, n_row;
    logic [PW-1:0] r_plane, n_plane;
    logic [CW-1:0] r_col, n_col;
    logic [DW-1:0] r_dwell, n_dwell;
    t_tick_ctrl    r_ctrl, n_ctrl;
    logic [PW-1:0] r_out_plane;

    logic [DELAY_W-1:0] unit;
    logic [DW-1:0]      limit;
    logic [DW-1:0]      dwell_inc;
    logic [RW+3:0]      row_ext;
    logic               rd_en;

    always_comb begin
        n_phase   = r_phase;
        n_row     = r_row;
        n_plane   = r_plane;
        n_col     = r_col;
        n_dwell   = r_dwell;
        rd_en     = 1'b0;
        unit      = (i_delay_unit == '0) ? DELAY_W'(1) : i_delay_unit;
        limit     = DW'(unit) << r_plane;
        dwell_inc = r_dwell + DW'(1);
        row_ext   = {4'b0, r_row};

        n_ctrl.row_select   = row_ext[3:0];
        n_ctrl.shift_strobe = 1'b0;
        n_ctrl.latch_strobe = 1'b0;
        n_ctrl.blank_n      = 1'b1;
        n_ctrl.frame_done   = 1'b0;

        if (i_run) begin
            case (r_phase)
                PH_LATCH: begin
                    n_ctrl.latch_strobe = 1'b1;
                    n_phase             = PH_DWELL;
                    n_dwell             = '0;
                end
                PH_DWELL: begin
                    n_ctrl.blank_n = 1'b0;
                    if (dwell_inc >= limit) begin
                        n_dwell = '0;
                        n_phase = PH_SHIFT;
                        if (r_plane == PW'(COLOR_BITS - 1)) begin
                            n_plane = '0;
                            if (r_row == RW'(ROW_PAIRS - 1)) begin
                                n_row             = '0;
                                n_ctrl.frame_done = 1'b1;
                            end else begin
                                n_row = r_row + RW'(1);
                            end
                        end else begin
                            n_plane = r_plane + PW'(1);
                        end
                    end else begin
                        n_dwell = dwell_inc;
                    end
                end
                default: begin
                    // shift phase, and the unused code acts the same
                    n_ctrl.shift_strobe = 1'b1;
                    rd_en               = 1'b1;
                    if (r_col == CW'(PANEL_WIDTH - 1)) begin
                        n_col   = '0;
                        n_phase = PH_LATCH;
                    end else begin
                        n_col   = r_col + CW'(1);
                        n_phase = PH_SHIFT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SHIFT;
            r_row       <= '0;
            r_plane     <= '0;
            r_col       <= '0;
            r_dwell     <= '0;
            r_ctrl      <= '0;
            r_out_plane <= '0;
        end else if (i_tick) begin
            r_phase     <= n_phase;
            r_row       <= n_row;
            r_plane     <= n_plane;
            r_col       <= n_col;
            r_dwell     <= n_dwell;
            r_ctrl      <= n_ctrl;
            r_out_plane <= r_plane;
        end
    end

    assign o_rd_en  = i_tick && rd_en;
    assign o_rd_row = r_row;
    assign o_rd_col = r_col;
    assign o_ctrl   = r_ctrl;
    assign o_plane  = r_out_plane;

endmodule

// ===== hw/rtl/led_matrix_bitplane_refresh.sv =====
// Refresh controller for a scanned RGB LED matrix with binary-code modulation.
// Every input word is a pixel write or a refresh tick, and a new word is accepted
// on every cycle while the output side keeps up; the pin word of a tick passes
// through the stage register (frame store read and sequencer controls) and then the
// output register, and that stage lets input be accepted until it fills while a
// finished word waits in the output register. After reset the frame store runs a
// clearing sweep over PANEL_HEIGHT / SCAN_HALVES times the next power of two at or
// above PANEL_WIDTH words (1024 for a 64x32 panel), during which no word is
// accepted; configuration writes are taken at any time.
// Depends on lmbr_pkg, lmbr_in_if, lmbr_out_if, lmbr_frame_store, lmbr_sequencer.
`timescale 1ns / 1ps

module led_matrix_bitplane_refresh import lmbr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int COLOR_BITS   = DEF_COLOR_BITS,
    parameter int SCAN_HALVES  = DEF_SCAN_HALVES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lmbr_in_if.sink               i_pix,
    lmbr_out_if.source            o_pin
);

    localparam int ROW_PAIRS = PANEL_HEIGHT / SCAN_HALVES;
    localparam int RW        = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
    localparam int CW        = $clog2(PANEL_WIDTH);
    localparam int PW        = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1;
    localparam int DATA_W    = 3 * COLOR_BITS;

    // configuration registers
    logic [DELAY_W-1:0] r_delay_unit;
    logic               r_run_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_unit <= DELAY_RESET;
            r_run_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELAY_UNIT: r_delay_unit <= i_cfg_data[DELAY_W-1:0];
                CFG_RUN_ENABLE: r_run_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake and pipeline control
    logic r_s1_valid;
    logic r_out_valid;
    logic advance;
    logic in_fire;
    logic tick_fire;
    logic write_fire;
    logic busy;

    assign advance    = !r_out_valid || o_pin.ready;
    assign i_pix.ready = !busy && (!r_s1_valid || advance);
    assign in_fire    = i_pix.valid && i_pix.ready;
    assign tick_fire  = in_fire && (i_pix.operation == OP_TICK);
    assign write_fire = in_fire && (i_pix.operation == OP_PIXEL_WRITE);

    // pixel write decode
    logic [8:0]          x_ext;
    logic [8:0]          y_ext;
    logic [8:0]          y_half;
    logic                wr_in_range;
    logic                wr_lower;
    logic [RW-1:0]       wr_row;
    logic [CW-1:0]       wr_col;
    logic [COLOR_BITS+LEVEL_W-1:0] red_ext;
    logic [COLOR_BITS+LEVEL_W-1:0] grn_ext;
    logic [COLOR_BITS+LEVEL_W-1:0] blu_ext;
    logic [DATA_W-1:0]   wr_data;

    always_comb begin
        x_ext       = {3'b0, i_pix.pixel_x};
        y_ext       = {4'b0, i_pix.pixel_y};
        wr_in_range = (x_ext < 9'(PANEL_WIDTH)) && (y_ext < 9'(PANEL_HEIGHT));
        wr_lower    = (SCAN_HALVES > 1) && (y_ext >= 9'(ROW_PAIRS));
        y_half      = wr_lower ? (y_ext - 9'(ROW_PAIRS)) : y_ext;
        wr_row      = y_half[RW-1:0];
        wr_col      = x_ext[CW-1:0];
        // levels are cut to the stored channel width
        red_ext     = {{COLOR_BITS{1'b0}}, i_pix.red_level};
        grn_ext     = {{COLOR_BITS{1'b0}}, i_pix.green_level};
        blu_ext     = {{COLOR_BITS{1'b0}}, i_pix.blue_level};
        wr_data     = {blu_ext[COLOR_BITS-1:0], grn_ext[COLOR_BITS-1:0],
                       red_ext[COLOR_BITS-1:0]};
    end

    // sequencer and frame store
    logic              rd_en;
    logic [RW-1:0]     rd_row;
    logic [CW-1:0]     rd_col;
    t_tick_ctrl        s1_ctrl;
    logic [PW-1:0]     s1_plane;
    logic [DATA_W-1:0] rd_upper;
    logic [DATA_W-1:0] rd_lower;

    lmbr_sequencer #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .COLOR_BITS   (COLOR_BITS),
        .SCAN_HALVES  (SCAN_HALVES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_fire),
        .i_run        (r_run_enable),
        .i_delay_unit (r_delay_unit),
        .o_rd_en      (rd_en),
        .o_rd_row     (rd_row),
        .o_rd_col     (rd_col),
        .o_ctrl       (s1_ctrl),
        .o_plane      (s1_plane)
    );

    lmbr_frame_store #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .COLOR_BITS   (COLOR_BITS),
        .SCAN_HALVES  (SCAN_HALVES)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_we         (write_fire && wr_in_range),
        .i_wr_lower   (wr_lower),
        .i_wr_row     (wr_row),
        .i_wr_col     (wr_col),
        .i_wr_data    (wr_data),
        .i_rd_en      (rd_en),
        .i_rd_row     (rd_row),
        .i_rd_col     (rd_col),
        .o_rd_upper   (rd_upper),
        .o_rd_lower   (rd_lower),
        .o_busy       (busy)
    );

    // bit plane select from the stored word
    function automatic logic [RGB_W-1:0] plane_rgb(input logic [DATA_W-1:0] px,
                                                   input logic [PW-1:0] plane);
        logic [COLOR_BITS-1:0] r;
        logic [COLOR_BITS-1:0] g;
        logic [COLOR_BITS-1:0] b;
        r = px[COLOR_BITS-1:0];
        g = px[2*COLOR_BITS-1:COLOR_BITS];
        b = px[3*COLOR_BITS-1:2*COLOR_BITS];
        return {b[plane], g[plane], r[plane]};
    endfunction

    // output register
    t_tick_ctrl       r_out_ctrl;
    logic [RGB_W-1:0] r_out_upper;
    logic [RGB_W-1:0] r_out_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (tick_fire) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_ctrl  <= s1_ctrl;
            r_out_upper <= s1_ctrl.shift_strobe ? plane_rgb(rd_upper, s1_plane) : '0;
            r_out_lower <= s1_ctrl.shift_strobe ? plane_rgb(rd_lower, s1_plane) : '0;
        end
    end

    assign o_pin.valid        = r_out_valid;
    assign o_pin.row_select   = r_out_ctrl.row_select;
    assign o_pin.upper_rgb    = r_out_upper;
    assign o_pin.lower_rgb    = r_out_lower;
    assign o_pin.shift_strobe = r_out_ctrl.shift_strobe;
    assign o_pin.latch_strobe = r_out_ctrl.latch_strobe;
    assign o_pin.blank_n      = r_out_ctrl.blank_n;
    assign o_pin.frame_done   = r_out_ctrl.frame_done;

    // checks
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_pix.ready
    ) else $error("word accepted during frame store clearing");

    a_tick_fills_stage: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        tick_fire |=> r_s1_valid
    ) else $error("accepted tick lost before output stage");

    a_stage_holds_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_pin.ready) |=> r_s1_valid && !$past(tick_fire)
    ) else $error("pending tick dropped or overwritten while output stalled");

    a_lit_only_in_dwell: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_pin.valid && !o_pin.blank_n) |->
            (!o_pin.shift_strobe && !o_pin.latch_strobe)
    ) else $error("panel enabled during shift or latch");

    a_frame_done_on_dwell: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_pin.valid && o_pin.frame_done) |-> !o_pin.blank_n
    ) else $error("frame end flagged outside a display tick");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking bench for led_matrix_bitplane_refresh: directed table, then random phases
// depends on lmbr_pkg, lmbr_in_if, lmbr_out_if and the block's rtl
`timescale 1ns / 1ps

module testbench;
    import lmbr_pkg::*;

    localparam int ROW_PAIRS      = DEF_PANEL_HEIGHT / DEF_SCAN_HALVES;
    localparam int STORE_WORDS    = DEF_PANEL_WIDTH * DEF_PANEL_HEIGHT;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DIR_ROWS       = 22;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {SEQ_SHIFT, SEQ_LATCH, SEQ_DWELL} t_seq_phase;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [PIX_X_W-1:0] pixel_x;
        logic [PIX_Y_W-1:0] pixel_y;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_in_word;

    typedef struct packed {
        logic [ROW_SEL_W-1:0] row_select;
        logic [RGB_W-1:0]     upper_rgb;
        logic [RGB_W-1:0]     lower_rgb;
        logic                 shift_strobe;
        logic                 latch_strobe;
        logic                 blank_n;
        logic                 frame_done;
    } t_pin_word;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in_word              word;
        logic                  typed;
        t_pin_word             want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lmbr_in_if  pix_if ();
    lmbr_out_if pin_if ();

    led_matrix_bitplane_refresh uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_if),
        .o_pin       (pin_if)
    );

    // shadow of the block: frame store, scan counters and registers
    logic [3*LEVEL_W-1:0] pix_store [STORE_WORDS];
    int unsigned          seq_row;
    int unsigned          seq_plane;
    int unsigned          seq_col;
    t_seq_phase           seq_phase;
    int unsigned          seq_dwell;
    logic [DELAY_W-1:0]   reg_delay;
    logic                 reg_run;

    t_pin_word   pin_expect_q [$];
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles  = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_left = 0;
    bit          hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [RGB_W-1:0] plane_rgb(input int unsigned row,
                                                   input int unsigned col);
        logic [3*LEVEL_W-1:0] px;
        px = pix_store[row * DEF_PANEL_WIDTH + col];
        return {px[2*DEF_COLOR_BITS + seq_plane], px[DEF_COLOR_BITS + seq_plane], px[seq_plane]};
    endfunction

    // returns 1 when the word gives a pin word, advancing the shadow state
    function automatic bit predict_pins(input t_in_word w, output t_pin_word res);
        int unsigned unit;
        res = '0;
        if (w.operation == OP_PIXEL_WRITE) begin
            pix_store[{w.pixel_y, w.pixel_x}] = {w.blue_level, w.green_level, w.red_level};
            return 1'b0;
        end
        res.row_select = ROW_SEL_W'(seq_row);
        res.blank_n    = 1'b1;
        if (reg_run) begin
            case (seq_phase)
                SEQ_LATCH: begin
                    res.latch_strobe = 1'b1;
                    seq_phase = SEQ_DWELL;
                    seq_dwell = 0;
                end
                SEQ_DWELL: begin
                    unit = (reg_delay == 0) ? 1 : int'(reg_delay);
                    res.blank_n = 1'b0;
                    seq_dwell++;
                    if (seq_dwell >= (unit << seq_plane)) begin
                        seq_dwell = 0;
                        seq_phase = SEQ_SHIFT;
                        seq_plane++;
                        if (seq_plane >= DEF_COLOR_BITS) begin
                            seq_plane = 0;
                            seq_row++;
                            if (seq_row >= ROW_PAIRS) begin
                                seq_row = 0;
                                res.frame_done = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    res.shift_strobe = 1'b1;
                    res.upper_rgb = plane_rgb(seq_row, seq_col);
                    if (DEF_SCAN_HALVES > 1)
                        res.lower_rgb = plane_rgb(seq_row + ROW_PAIRS, seq_col);
                    seq_col++;
                    seq_phase = SEQ_SHIFT;
                    if (seq_col >= DEF_PANEL_WIDTH) begin
                        seq_col = 0;
                        seq_phase = SEQ_LATCH;
                    end
                end
            endcase
        end
        return 1'b1;
    endfunction

    function automatic t_in_word tick_w();
        t_in_word w;
        w = '0;
        w.operation = OP_TICK;
        return w;
    endfunction

    function automatic t_in_word pix_w(input int x, input int y, input int r, input int g,
                                       input int b);
        t_in_word w;
        w.operation   = OP_PIXEL_WRITE;
        w.pixel_x     = PIX_X_W'(x);
        w.pixel_y     = PIX_Y_W'(y);
        w.red_level   = LEVEL_W'(r);
        w.green_level = LEVEL_W'(g);
        w.blue_level  = LEVEL_W'(b);
        return w;
    endfunction

    function automatic t_pin_word pins(input int row, input int up, input int lo,
                                       input bit sh, input bit la, input bit bl, input bit dn);
        t_pin_word p;
        p.row_select   = ROW_SEL_W'(row);
        p.upper_rgb    = RGB_W'(up);
        p.lower_rgb    = RGB_W'(lo);
        p.shift_strobe = sh;
        p.latch_strobe = la;
        p.blank_n      = bl;
        p.frame_done   = dn;
        return p;
    endfunction

    function automatic t_dir_row item_t(input t_in_word w, input t_pin_word p);
        t_dir_row d;
        d = '0;
        d.word  = w;
        d.typed = 1'b1;
        d.want  = p;
        return d;
    endfunction

    function automatic t_dir_row item(input t_in_word w);
        t_dir_row d;
        d = '0;
        d.word = w;
        return d;
    endfunction

    function automatic t_dir_row cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        t_dir_row d;
        d = '0;
        d.is_cfg  = 1'b1;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    // directed stimulus; rows with a typed pin word bypass the shadow's result
    function automatic t_dir_row dir_entry(input int n);
        case (n)
            0:  return item_t(tick_w(), pins(0, 0, 0, 0, 0, 1, 0));   // stopped after reset
            1:  return item(pix_w(0, 0, 15, 15, 15));
            2:  return item(pix_w(0, 16, 15, 0, 15));
            3:  return item(pix_w(63, 31, 15, 15, 15));
            4:  return item(pix_w(1, 0, 5, 10, 0));
            5:  return item(pix_w(1, 16, 10, 5, 15));
            6:  return item_t(tick_w(), pins(0, 0, 0, 0, 0, 1, 0));
            7:  return cfg(CFG_DELAY_UNIT, 16'd0);                   // zero unit acts as one
            8:  return cfg(CFG_RUN_ENABLE, 16'd1);
            9:  return item_t(tick_w(), pins(0, 7, 5, 1, 0, 1, 0));   // first column, plane 0
            10: return item(tick_w());
            11: return item(pix_w(2, 0, 15, 15, 15));                 // write just ahead of the scan
            12: return item(tick_w());
            13: return cfg(CFG_RUN_ENABLE, 16'd0);
            14: return item_t(tick_w(), pins(0, 0, 0, 0, 0, 1, 0));   // held mid-row
            15: return cfg(CFG_RUN_ENABLE, 16'd1);
            16: return item(tick_w());
            17: return cfg(CFG_DELAY_UNIT, 16'hFFFF);
            18: return item(tick_w());
            19: return item(pix_w(63, 31, 0, 0, 0));
            20: return item(tick_w());
            default: return cfg(CFG_DELAY_UNIT, 16'd1);
        endcase
    endfunction

    // offer one word, hold it until taken, then record what it should give
    task automatic send_word(input t_in_word w, input bit typed, input t_pin_word want);
        t_pin_word res;
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.operation   <= w.operation;
        pix_if.pixel_x     <= w.pixel_x;
        pix_if.pixel_y     <= w.pixel_y;
        pix_if.red_level   <= w.red_level;
        pix_if.green_level <= w.green_level;
        pix_if.blue_level  <= w.blue_level;
        do @(posedge i_clk); while (!pix_if.ready);
        if (predict_pins(w, res))
            pin_expect_q.push_back(typed ? want : res);
    endtask

    // let every word drain, plus time for a trailing pixel write
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DELAY_UNIT: reg_delay = val[DELAY_W-1:0];
            CFG_RUN_ENABLE: reg_run   = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [DELAY_W-1:0] delay, input bit run);
        settle();
        write_reg(CFG_DELAY_UNIT, delay);
        write_reg(CFG_RUN_ENABLE, CFG_DATA_W'(run));
    endtask

    task automatic run_phase(input int n_items, input int unsigned src_idle,
                             input int unsigned sink_stall, input int unsigned write_pct,
                             input bit hold);
        t_in_word w;
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        if (hold)
            hold_req = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            w.operation   = ($urandom_range(99) < write_pct) ? OP_PIXEL_WRITE : OP_TICK;
            w.pixel_x     = PIX_X_W'($urandom_range(DEF_PANEL_WIDTH - 1));
            w.pixel_y     = PIX_Y_W'($urandom_range(DEF_PANEL_HEIGHT - 1));
            w.red_level   = LEVEL_W'($urandom_range(15));
            w.green_level = LEVEL_W'($urandom_range(15));
            w.blue_level  = LEVEL_W'($urandom_range(15));
            // often hit the pixel the next shift tick reads
            if (w.operation == OP_PIXEL_WRITE && $urandom_range(2) == 0) begin
                w.pixel_x = PIX_X_W'(seq_col);
                w.pixel_y = PIX_Y_W'(seq_row + ($urandom_range(1) ? ROW_PAIRS : 0));
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic report_mismatch(input string what, input t_pin_word want,
                                   input t_pin_word got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t %s: exp row %0d up %0d lo %0d sh %0b la %0b bl %0b dn %0b",
                     $realtime, what, want.row_select, want.upper_rgb, want.lower_rgb,
                     want.shift_strobe, want.latch_strobe, want.blank_n, want.frame_done);
            $display("    act row %0d up %0d lo %0d sh %0b la %0b bl %0b dn %0b",
                     got.row_select, got.upper_rgb, got.lower_rgb, got.shift_strobe,
                     got.latch_strobe, got.blank_n, got.frame_done);
        end
    endtask

    always @(posedge i_clk) begin : pin_check
        t_pin_word got;
        t_pin_word want;
        if (i_rst_n && pin_if.valid && pin_if.ready) begin
            got.row_select   = pin_if.row_select;
            got.upper_rgb    = pin_if.upper_rgb;
            got.lower_rgb    = pin_if.lower_rgb;
            got.shift_strobe = pin_if.shift_strobe;
            got.latch_strobe = pin_if.latch_strobe;
            got.blank_n      = pin_if.blank_n;
            got.frame_done   = pin_if.frame_done;
            if (pin_expect_q.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
            end else begin
                want = pin_expect_q.pop_front();
                if (got.row_select !== want.row_select || got.upper_rgb !== want.upper_rgb
                    || got.lower_rgb !== want.lower_rgb
                    || got.shift_strobe !== want.shift_strobe
                    || got.latch_strobe !== want.latch_strobe
                    || got.blank_n !== want.blank_n || got.frame_done !== want.frame_done)
                    report_mismatch("pin word mismatch", want, got);
            end
        end
    end

    // receiver: random stalls, or a long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            pin_if.ready <= 1'b0;
        end else begin
            pin_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (pin_if.valid && pin_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : main_seq
        t_dir_row row;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        pix_if.valid       = 1'b0;
        pix_if.operation   = '0;
        pix_if.pixel_x     = '0;
        pix_if.pixel_y     = '0;
        pix_if.red_level   = '0;
        pix_if.green_level = '0;
        pix_if.blue_level  = '0;
        pin_if.ready       = 1'b0;
        for (int a = 0; a < STORE_WORDS; a++)
            pix_store[a] = '0;
        seq_row   = 0;
        seq_plane = 0;
        seq_col   = 0;
        seq_phase = SEQ_SHIFT;
        seq_dwell = 0;
        reg_delay = DELAY_RESET;
        reg_run   = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++) begin
            row = dir_entry(n);
            if (row.is_cfg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_word(row.word, row.typed, row.want);
            end
        end

        // shortest dwell so the scan runs through every plane into the next row pair
        program_regs(16'd1, 1'b1);
        run_phase(300, 0, 0, 5, 1'b0);

        program_regs(DELAY_W'($urandom_range(3)), 1'b1);
        run_phase(130, 0, 0, 15, 1'b0);
        program_regs(DELAY_W'($urandom_range(3)), 1'b1);
        run_phase(130, 72, 0, 15, 1'b0);
        program_regs(DELAY_W'($urandom_range(3)), 1'b1);
        run_phase(130, 0, 72, 15, 1'b0);
        program_regs(DELAY_W'($urandom_range(3)), 1'b1);
        run_phase(130, 23, 23, 15, 1'b0);

        program_regs(16'd2, 1'b1);
        run_phase(120, 0, 0, 15, 1'b1);
        program_regs(16'd3, 1'b0);
        run_phase(40, 23, 23, 15, 1'b0);
        program_regs(16'hFFFF, 1'b1);
        run_phase(60, 0, 72, 15, 1'b0);

        settle();
        if (mismatch_cnt == 0 && pin_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lmbr_pkg.sv
hw/rtl/lmbr_in_if.sv
hw/rtl/lmbr_out_if.sv
hw/rtl/lmbr_frame_store.sv
hw/rtl/lmbr_sequencer.sv
hw/rtl/led_matrix_bitplane_refresh.sv
tb/sv/testbench.sv
